FILE: hdl/hea_pkg.sv
`default_nettype none
package hea_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 64;
  localparam int EXP_W       = 6;
  localparam int LOG_W       = EXP_W + FRAC_BITS;
  localparam int OUT_W       = 24;
  localparam int NORM_STEPS  = 6;
  localparam int STEP_W      = $clog2(FRAC_BITS);
  localparam int NSTEP_W     = $clog2(NORM_STEPS);
  localparam int DIV_W       = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] COUNT_MASK = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [DATA_W-1:0] SAT_MAX    = '1;
  localparam logic [OUT_W-1:0]  OUT_MAX    = '1;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_BOUND_MODE = 2'd0;
  localparam logic [1:0] REG_TOTAL      = 2'd1;
  localparam logic [1:0] REG_COUNTED    = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] value;
  } term_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] term;
  } term_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/hea_mul.sv
`default_nettype none
module hea_mul (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);
  // Shared 32x32 unsigned multiplier; callers register the product.
  assign p = 64'(a) * 64'(b);
endmodule
`default_nettype wire

FILE: hdl/hea_term_unit.sv
`default_nettype none
module hea_term_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hea_pkg::term_req_t  req,
  output hea_pkg::term_rsp_t       rsp
);
  import hea_pkg::*;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_NORM = 5'b00010,
    T_SQR  = 5'b00100,
    T_MLO  = 5'b01000,
    T_MHI  = 5'b10000
  } tstate_t;

  tstate_t            state;
  logic [DATA_W-1:0]  value;
  logic [DATA_W-1:0]  norm;
  logic [EXP_W-1:0]   expo;
  logic [FRAC_BITS-1:0] frac;
  logic [31:0]        x;
  logic [STEP_W-1:0]  sstep;
  logic [NSTEP_W-1:0] nstep;
  logic [63:0]        prod_lo;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [LOG_W-1:0]   log_val;
  logic [6:0]         shamt;
  logic [32:0]        sq;
  logic [64:0]        total;
  logic               hi_ovf;

  assign log_val = {expo, frac};
  assign shamt   = 7'd32 >> nstep;
  assign sq      = mul_p[63:31];
  assign hi_ovf  = mul_p[63:32] != 32'd0;
  assign total   = {1'b0, prod_lo} + {1'b0, mul_p[31:0], 32'd0};

  always_comb begin
    unique case (state)
      T_SQR: begin
        mul_a = x;
        mul_b = x;
      end
      T_MLO: begin
        mul_a = value[31:0];
        mul_b = 32'(log_val);
      end
      T_MHI: begin
        mul_a = value[63:32];
        mul_b = 32'(log_val);
      end
      default: begin
        mul_a = x;
        mul_b = x;
      end
    endcase
  end

  hea_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            value <= req.value;
            norm  <= req.value;
            expo  <= '1;
            nstep <= '0;
            if (req.value < 64'd2) begin
              rsp.done <= 1'b1;
              rsp.sat  <= 1'b0;
              rsp.term <= '0;
            end else begin
              state <= T_NORM;
            end
          end
        end
        T_NORM: begin
          // Binary search for the top set bit, halving the shift each step.
          if ((norm >> (7'd64 - shamt)) == 64'd0) begin
            norm <= norm << shamt;
            expo <= expo - EXP_W'(shamt);
          end
          nstep <= nstep + 1'b1;
          if (nstep == NSTEP_W'(NORM_STEPS - 1)) begin
            state <= T_SQR;
            sstep <= '0;
          end
        end
        T_SQR: begin
          if (sstep == '0) begin
            // First pass squares the normalized mantissa taken from norm.
          end
          frac  <= {frac[FRAC_BITS-2:0], sq[32]};
          x     <= sq[32] ? sq[32:1] : sq[31:0];
          sstep <= sstep + 1'b1;
          if (sstep == STEP_W'(FRAC_BITS - 1)) begin
            state <= T_MLO;
          end
        end
        T_MLO: begin
          prod_lo <= mul_p;
          state   <= T_MHI;
        end
        T_MHI: begin
          rsp.done <= 1'b1;
          rsp.sat  <= hi_ovf | total[64];
          rsp.term <= (hi_ovf | total[64]) ? SAT_MAX : total[63:0];
          state    <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
      if (state == T_NORM && nstep == NSTEP_W'(NORM_STEPS - 1)) begin
        // Mantissa as Q1.31 comes from the top half after normalizing.
        if ((norm >> (7'd64 - shamt)) == 64'd0) begin
          x <= 32'((norm << shamt) >> 32);
        end else begin
          x <= norm[63:32];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/histogram_entropy_accumulator.sv
`default_nettype none
// Histogram entropy accumulator. Bucket counts arrive one per input request
// (tdata holds the count, tlast marks the final bucket). Each count v of 2 or
// more adds v*log2(v) in fixed point with FRAC_BITS fraction bits to a
// saturating 64-bit sum, and the largest count is tracked. On the final bucket
// one result request carries the sum divided by total_preimages as unsigned
// Q8.16 in tdata and an error flag in tuser (zero total or saturation). In
// upper-bound mode the residue total minus counted (floored at zero) is first
// added to the largest bucket. Each v*log2(v) term runs through one term unit
// built around a single shared 32x32 multiplier: a count of 2 or more passes
// through 6 normalize steps, FRAC_BITS squarings and two partial products,
// and a count of 0 or 1 skips these steps. The final bucket additionally
// takes up to two more term evaluations in upper-bound mode and a restoring
// divide, after which the result waits for the consumer. The input is not
// ready while an item is in progress. Configuration is written through
// cfg_we, cfg_addr and cfg_data; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module histogram_entropy_accumulator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] bucket_count
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [23:0] entropy_value
  output logic             m_axis_tuser    // error_flag
);
  import hea_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TERM = 9'b000000010,
    S_FIN  = 9'b000000100,
    S_OLD  = 9'b000001000,
    S_NEW  = 9'b000010000,
    S_SUB  = 9'b000100000,
    S_ADD  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t            state;
  logic              bound_mode;
  logic [DATA_W-1:0] total_preimages;
  logic [DATA_W-1:0] counted_preimages;
  logic [DATA_W-1:0] term_sum;
  logic [DATA_W-1:0] largest_count;
  logic              sum_saturated;
  logic              last;
  logic              fin_sat;
  logic [DATA_W-1:0] t_old;
  logic [DATA_W-1:0] big;
  logic [DATA_W:0]   rem;
  logic [DIV_W-1:0]  div_cnt;
  term_req_t         req;
  term_rsp_t         rsp;
  logic [DATA_W-1:0] v_in;
  logic [DATA_W:0]   acc_sum;
  logic [DATA_W-1:0] residue;
  logic [DATA_W:0]   big_sum;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W+1:0] rem_diff;

  function automatic logic acc_sum_b_ovf(input logic [DATA_W-1:0] a,
                                         input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W];
  endfunction

  assign v_in      = 64'(s_axis_tdata) & COUNT_MASK;
  assign acc_sum   = {1'b0, term_sum} + {1'b0, rsp.term};
  assign residue   = (total_preimages > counted_preimages) ?
                     total_preimages - counted_preimages : '0;
  assign big_sum   = {1'b0, largest_count} + {1'b0, residue};
  assign rem_shift = {rem[DATA_W-1:0], term_sum[DATA_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b0, total_preimages};

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = state == S_OUT;

  hea_term_unit u_term (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_mode        <= 1'b0;
      total_preimages   <= 64'd1;
      counted_preimages <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BOUND_MODE: bound_mode        <= cfg_data[0];
        REG_TOTAL:      total_preimages   <= cfg_data;
        REG_COUNTED:    counted_preimages <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    req.start <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      term_sum      <= '0;
      largest_count <= '0;
      sum_saturated <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            last <= s_axis_tlast;
            if (v_in > largest_count) begin
              largest_count <= v_in;
            end
            if (sum_saturated) begin
              state <= s_axis_tlast ? S_FIN : S_IDLE;
            end else begin
              req.start <= 1'b1;
              req.value <= v_in;
              state     <= S_TERM;
            end
          end
        end
        S_TERM: begin
          if (rsp.done) begin
            if (rsp.sat || acc_sum[DATA_W]) begin
              sum_saturated <= 1'b1;
              term_sum      <= SAT_MAX;
            end else begin
              term_sum <= acc_sum[DATA_W-1:0];
            end
            state <= last ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          fin_sat <= sum_saturated;
          big     <= big_sum[DATA_W] ? SAT_MAX : big_sum[DATA_W-1:0];
          rem     <= '0;
          div_cnt <= '0;
          if (bound_mode && largest_count != '0 && !sum_saturated) begin
            req.start <= 1'b1;
            req.value <= largest_count;
            state     <= S_OLD;
          end else begin
            state <= S_DIV;
          end
        end
        S_OLD: begin
          if (rsp.done) begin
            t_old     <= rsp.term;
            fin_sat   <= fin_sat | rsp.sat;
            req.start <= 1'b1;
            req.value <= big;
            state     <= S_NEW;
          end
        end
        S_NEW: begin
          if (rsp.done) begin
            big     <= rsp.term;
            fin_sat <= fin_sat | rsp.sat;
            state   <= S_SUB;
          end
        end
        S_SUB: begin
          term_sum <= (term_sum >= t_old) ? term_sum - t_old : '0;
          state    <= S_ADD;
        end
        S_ADD: begin
          // The new term was parked in big.
          if (acc_sum_b_ovf(term_sum, big)) begin
            fin_sat <= 1'b1;
          end
          term_sum <= term_sum + big;
          state    <= S_DIV;
        end
        S_DIV: begin
          // Restoring divide, one quotient bit per cycle shifted into term_sum.
          if (total_preimages == '0 || fin_sat) begin
            state <= S_OUT;
            m_axis_tdata <= (total_preimages == '0) ? '0 : OUT_MAX;
            m_axis_tuser <= 1'b1;
          end else begin
            if (!rem_diff[DATA_W+1]) begin
              rem <= rem_diff[DATA_W:0];
            end else begin
              rem <= rem_shift;
            end
            term_sum <= {term_sum[DATA_W-2:0], !rem_diff[DATA_W+1]};
            div_cnt  <= div_cnt + 1'b1;
            if (div_cnt == DIV_W'(DATA_W - 1)) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            term_sum      <= '0;
            largest_count <= '0;
            sum_saturated <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && total_preimages != '0 && !fin_sat &&
          div_cnt == DIV_W'(DATA_W - 1)) begin
        if (term_sum[DATA_W-2:OUT_W-1] != '0) begin
          m_axis_tdata <= OUT_MAX;
        end else begin
          m_axis_tdata <= {term_sum[OUT_W-2:0], !rem_diff[DATA_W+1]};
        end
        m_axis_tuser <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import hea_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [63:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] bucket_count
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [23:0] entropy_value
  logic        m_axis_tuser;   // error_flag

  histogram_entropy_accumulator u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // One entropy result as the block reports it.
  typedef struct packed {
    logic [23:0] entropy;
    logic        err;
  } entropy_res_t;

  // Mirror of the configuration registers and of the per-histogram state.
  logic        mode_upper;
  logic [63:0] total_cfg;
  logic [63:0] counted_cfg;
  logic [63:0] acc_sum;
  logic [63:0] max_count;
  logic        acc_sat;

  entropy_res_t pending_entropy[$];
  bit           failed;
  bit           quiet_tail;
  longint       cycle_cnt;
  int           stall_left;

  localparam longint CYCLE_LIMIT = 2000000;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fixed-point log2: integer part is the top set bit, then repeated squaring
  // of a Q1.31 mantissa yields one fraction bit per step.
  function automatic logic [63:0] log2_fixed(input logic [63:0] v);
    int          e;
    logic [63:0] x;
    logic [127:0] sq;
    logic [63:0] frac;
    e = 63;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e >= 31) x = v >> (e - 31);
    else x = v << (31 - e);
    frac = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      sq = x * x;
      x = sq[94:31];
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    return (64'(e) << FRAC_BITS) | frac;
  endfunction

  // v*log2(v) with saturation; counts below 2 contribute nothing.
  function automatic logic [63:0] plogp_term(input logic [63:0] v, inout logic sat);
    logic [127:0] p;
    if (v < 2) return '0;
    p = v * log2_fixed(v);
    if (p[127:64] != 0) begin
      sat = 1'b1;
      return SAT_MAX;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] add_clamp(input logic [63:0] a, input logic [63:0] b,
                                            inout logic sat);
    logic [64:0] s;
    s = a + b;
    if (s[64]) begin
      sat = 1'b1;
      return SAT_MAX;
    end
    return s[63:0];
  endfunction

  // Advances the predicted state by one bucket and queues a result on the
  // final bucket of a histogram.
  function automatic void predict_bucket(input logic [31:0] cnt, input logic last);
    logic [63:0] v, s, res, big, t_old, t_new, q;
    logic        sat, st;
    entropy_res_t r;
    v = 64'(cnt) & COUNT_MASK;
    if (!acc_sat) begin
      st = acc_sat;
      s = plogp_term(v, st);
      acc_sum = add_clamp(acc_sum, s, st);
      acc_sat = st;
    end
    if (v > max_count) max_count = v;
    if (!last) return;
    s = acc_sum;
    sat = acc_sat;
    if (mode_upper && max_count != 0 && !sat) begin
      res = (total_cfg > counted_cfg) ? total_cfg - counted_cfg : '0;
      big = (max_count > SAT_MAX - res) ? SAT_MAX : max_count + res;
      t_old = plogp_term(max_count, sat);
      t_new = plogp_term(big, sat);
      s = (s >= t_old) ? s - t_old : '0;
      s = add_clamp(s, t_new, sat);
    end
    if (total_cfg == 0) begin
      r.entropy = '0;
      r.err = 1'b1;
    end else if (sat) begin
      r.entropy = OUT_MAX;
      r.err = 1'b1;
    end else begin
      q = s / total_cfg;
      r.entropy = (q > 64'(OUT_MAX)) ? OUT_MAX : q[23:0];
      r.err = 1'b0;
    end
    pending_entropy = {pending_entropy, r};
    acc_sum = '0;
    max_count = '0;
    acc_sat = 1'b0;
  endfunction

  // Result side: random stall bursts, compare every accepted result in order.
  always @(posedge clk) begin
    entropy_res_t exp_r;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_entropy.size() == 0) begin
          $display("%0t: unexpected result entropy=%h err=%b", $time,
                   m_axis_tdata, m_axis_tuser);
          failed = 1'b1;
        end else begin
          exp_r = pending_entropy.pop_front();
          if (m_axis_tdata !== exp_r.entropy) begin
            $display("%0t: entropy_value expected %h actual %h", $time,
                     exp_r.entropy, m_axis_tdata);
            failed = 1'b1;
          end
          if (m_axis_tuser !== exp_r.err) begin
            $display("%0t: error_flag expected %b actual %b", $time,
                     exp_r.err, m_axis_tuser);
            failed = 1'b1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL histogram_entropy_accumulator");
      $finish;
    end
  end

  // Register write at the next edge; the mirror follows at once because the
  // block is idle whenever this is called.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BOUND_MODE: mode_upper = val[0];
      REG_TOTAL:      total_cfg = val;
      REG_COUNTED:    counted_cfg = val;
      default: ;
    endcase
  endtask

  // Sends one bucket request, with a random idle burst first unless in the tail.
  task automatic send_bucket(input logic [31:0] cnt, input logic last);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cnt;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_bucket(cnt, last);
  endtask

  // Waits until every queued result has arrived, then lets the block settle.
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (pending_entropy.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Directed rows: count, last flag, and a hand-known result where one exists.
  typedef struct {
    logic [31:0] cnt;
    logic        last;
    bit          known;
    logic [23:0] entropy;
    logic        err;
  } bucket_row_t;

  bucket_row_t directed_rows[] = '{
    '{32'd0, 1'b1, 1'b1, 24'h0, 1'b0},          // empty histogram right after reset
    '{32'd1, 1'b1, 1'b1, 24'h0, 1'b0},          // a count of one adds no term
    '{32'd2, 1'b1, 1'b1, 24'h20000, 1'b0},      // 2*log2(2) = 2.0
    '{32'd4, 1'b0, 1'b0, 24'h0, 1'b0},
    '{32'd3, 1'b0, 1'b0, 24'h0, 1'b0},
    '{32'd0, 1'b0, 1'b0, 24'h0, 1'b0},
    '{32'd1, 1'b1, 1'b0, 24'h0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b0}, // quotient clamps at the top
    '{32'h8000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, 24'h0, 1'b0},
    '{32'd5, 1'b0, 1'b0, 24'h0, 1'b0},
    '{32'd255, 1'b0, 1'b0, 24'h0, 1'b0},
    '{32'd65536, 1'b1, 1'b0, 24'h0, 1'b0}
  };

  task automatic run_directed;
    for (int i = 0; i < directed_rows.size(); i++) begin
      send_bucket(directed_rows[i].cnt, directed_rows[i].last);
      if (directed_rows[i].known) begin
        if (pending_entropy[$].entropy !== directed_rows[i].entropy ||
            pending_entropy[$].err !== directed_rows[i].err) begin
          $display("%0t: row %0d predictor expected %h/%b actual %h/%b", $time, i,
                   directed_rows[i].entropy, directed_rows[i].err,
                   pending_entropy[$].entropy, pending_entropy[$].err);
          failed = 1'b1;
        end
      end
    end
    drain_results();
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 255);
      2: return $urandom_range(0, 65535);
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFF_FFFF} & $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] rand_wide();
    case ($urandom_range(0, 4))
      0: return 64'(0);
      1: return 64'($urandom_range(1, 1000));
      2: return SAT_MAX;
      3: return {$urandom(), $urandom()};
      default: return 64'($urandom());
    endcase
  endfunction

  // Random histograms of 1 to 12 buckets under a given configuration.
  task automatic run_histograms(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      for (int b = 0; b < len; b++) begin
        send_bucket(rand_count(), b == len - 1);
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    failed = 1'b0;
    quiet_tail = 1'b0;
    cycle_cnt = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_BOUND_MODE;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    mode_upper = 1'b0;
    total_cfg = 64'd1;
    counted_cfg = '0;
    acc_sum = '0;
    max_count = '0;
    acc_sat = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Zero total reports the error flag; upper-bound mode with residue.
    write_reg(REG_TOTAL, 64'd0);
    send_bucket(32'd7, 1'b1);
    drain_results();
    write_reg(REG_BOUND_MODE, 64'd1);
    write_reg(REG_TOTAL, 64'd100);
    write_reg(REG_COUNTED, 64'd20);
    send_bucket(32'd10, 1'b0);
    send_bucket(32'd5, 1'b1);
    send_bucket(32'd0, 1'b1);          // no largest bucket takes the residue
    drain_results();
    write_reg(REG_COUNTED, 64'd500);   // negative residue saturates to zero
    send_bucket(32'd9, 1'b1);
    drain_results();
    write_reg(REG_TOTAL, SAT_MAX);     // enlarged count saturates, term overflows
    write_reg(REG_COUNTED, 64'd0);
    send_bucket(32'hFFFF_FFFF, 1'b1);
    drain_results();

    // Random phases, each under a fresh configuration including extremes.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_BOUND_MODE, 64'($urandom_range(0, 1)));
      write_reg(REG_TOTAL, (ph == 0) ? 64'd1 : rand_wide());
      write_reg(REG_COUNTED, rand_wide());
      if (ph == 11) quiet_tail = 1'b1;
      run_histograms(160);
    end

    if (!failed) begin
      $display("PASS histogram_entropy_accumulator");
    end else begin
      $display("FAIL histogram_entropy_accumulator");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/hea_pkg.sv
hdl/hea_mul.sv
hdl/hea_term_unit.sv
hdl/histogram_entropy_accumulator.sv
verif/tb_top.sv
